[src/lpcd_pkg.sv]
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared widths, register codes, reset values and stage bundles for the
// line pair corner detector.
// ----------------------------------------------------------------------------
package lpcd_pkg;

    localparam int COORD_W   = 16;
    localparam int DIR_FRAC  = 14;
    localparam int G_W       = 16;
    localparam int REG_W     = 16;
    localparam int OUT_DIR_W = 16;
    localparam int T_FRAC    = 16;
    localparam int EA_SH     = 20;

    localparam int N_W    = COORD_W + 1;
    localparam int PROD_W = 2 * N_W;
    localparam int CR_W   = PROD_W + 1;
    localparam int L2_W   = PROD_W;
    localparam int TNA_W  = CR_W + N_W;

    localparam int SQ_IN_W = L2_W + T_FRAC;
    localparam int SQ_W    = SQ_IN_W / 2;
    localparam int SQ_LAT  = SQ_W;

    localparam int DV_MAG_W  = TNA_W;
    localparam int DV_NUM_W  = DV_MAG_W + 1;
    localparam int DV_DMAG_W = CR_W;
    localparam int DV_DEN_W  = CR_W + 1;
    localparam int DV_LAT    = DV_MAG_W + 2;

    localparam int NR_W  = DV_NUM_W + 2;
    localparam int U_W   = DIR_FRAC + 3;
    localparam int DOT_W = 2 * U_W + 1;
    localparam int GP_W  = G_W + U_W + 1;
    localparam int CS_W  = DV_NUM_W + 1;

    localparam int NUM_STG = 5 + SQ_LAT + DV_LAT + 3;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACUTE_LO  = 3'd0,
        CFG_ACUTE_HI  = 3'd1,
        CFG_OBTUSE_LO = 3'd2,
        CFG_OBTUSE_HI = 3'd3,
        CFG_TOL       = 3'd4
    } t_cfg_idx;

    localparam logic signed [REG_W-1:0] RST_ACUTE_LO  = 16'sd0;
    localparam logic signed [REG_W-1:0] RST_ACUTE_HI  = 16'sd4240;
    localparam logic signed [REG_W-1:0] RST_OBTUSE_LO = -16'sd4240;
    localparam logic signed [REG_W-1:0] RST_OBTUSE_HI = 16'sd0;
    localparam logic [REG_W-1:0]        RST_TOL       = 16'd512;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax0;
        logic signed [COORD_W-1:0] ay0;
        logic signed [N_W-1:0]     nax;
        logic signed [N_W-1:0]     nay;
        logic signed [N_W-1:0]     nbx;
        logic signed [N_W-1:0]     nby;
        logic signed [G_W-1:0]     gax;
        logic signed [G_W-1:0]     gay;
        logic signed [G_W-1:0]     gbx;
        logic signed [G_W-1:0]     gby;
        logic signed [CR_W-1:0]    cr;
        logic signed [CR_W-1:0]    tn;
        logic signed [CR_W-1:0]    pn;
        logic signed [TNA_W-1:0]   tnax;
        logic signed [TNA_W-1:0]   tnay;
        logic                      degen;
    } t_geo;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax0;
        logic signed [COORD_W-1:0] ay0;
        logic signed [G_W-1:0]     gax;
        logic signed [G_W-1:0]     gay;
        logic signed [G_W-1:0]     gbx;
        logic signed [G_W-1:0]     gby;
        logic                      cr_neg;
        logic                      degen;
    } t_tail;

endpackage

[src/lpcd_sqrt.sv]
// ----------------------------------------------------------------------------
// lpcd_sqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module lpcd_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [lpcd_pkg::SQ_IN_W-1:0] i_val,
    output logic [lpcd_pkg::SQ_W-1:0]    o_root
);
    import lpcd_pkg::*;

    logic [SQ_W+1:0]    r_rem  [SQ_W];
    logic [SQ_W-1:0]    r_root [SQ_W];
    logic [SQ_IN_W-1:0] r_val  [SQ_W];

    logic [SQ_W+1:0]    w_rem_in  [SQ_W];
    logic [SQ_W-1:0]    w_root_in [SQ_W];
    logic [SQ_IN_W-1:0] w_val_in  [SQ_W];
    logic [SQ_W+3:0]    w_sh      [SQ_W];
    logic [SQ_W+3:0]    w_trial   [SQ_W];
    logic               w_ge      [SQ_W];
    logic [SQ_W+3:0]    w_df      [SQ_W];

    always_comb begin
        for (int k = 0; k < SQ_W; k++) begin
            if (k == 0) begin
                w_rem_in[k]  = '0;
                w_root_in[k] = '0;
                w_val_in[k]  = i_val;
            end else begin
                w_rem_in[k]  = r_rem[k-1];
                w_root_in[k] = r_root[k-1];
                w_val_in[k]  = r_val[k-1];
            end
            w_sh[k]    = {w_rem_in[k], w_val_in[k][SQ_IN_W-1 -: 2]};
            w_trial[k] = {2'b00, w_root_in[k], 2'b01};
            w_ge[k]    = (w_sh[k] >= w_trial[k]);
            w_df[k]    = w_ge[k] ? (w_sh[k] - w_trial[k]) : w_sh[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_W; k++) begin
                r_rem[k]  <= w_df[k][SQ_W+1:0];
                r_root[k] <= {w_root_in[k][SQ_W-2:0], w_ge[k]};
                r_val[k]  <= {w_val_in[k][SQ_IN_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQ_W-1];

endmodule

[src/lpcd_div.sv]
// ----------------------------------------------------------------------------
// lpcd_div
// Pipelined signed divider, one quotient bit per stage, with optional
// round half away from zero.
// ----------------------------------------------------------------------------
module lpcd_div (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic                                 i_rnd,
    input  logic signed [lpcd_pkg::DV_NUM_W-1:0] i_num,
    input  logic signed [lpcd_pkg::DV_DEN_W-1:0] i_den,
    output logic signed [lpcd_pkg::DV_NUM_W-1:0] o_quo
);
    import lpcd_pkg::*;

    logic [DV_MAG_W-1:0]  w_an;
    logic [DV_DMAG_W-1:0] w_ad;

    logic [DV_MAG_W-1:0]  r_nq  [DV_MAG_W+1];
    logic [DV_DMAG_W-1:0] r_rem [DV_MAG_W+1];
    logic [DV_DMAG_W-1:0] r_den [DV_MAG_W+1];
    logic                 r_neg [DV_MAG_W+1];
    logic signed [DV_NUM_W-1:0] r_quo;

    logic [DV_DMAG_W:0] w_sh [DV_MAG_W];
    logic               w_ge [DV_MAG_W];
    logic [DV_DMAG_W:0] w_df [DV_MAG_W];

    always_comb begin
        w_an = i_num[DV_NUM_W-1] ? DV_MAG_W'(-i_num) : DV_MAG_W'(i_num);
        w_ad = i_den[DV_DEN_W-1] ? DV_DMAG_W'(-i_den) : DV_DMAG_W'(i_den);
        for (int k = 0; k < DV_MAG_W; k++) begin
            w_sh[k] = {r_rem[k], r_nq[k][DV_MAG_W-1]};
            w_ge[k] = (w_sh[k] >= {1'b0, r_den[k]});
            w_df[k] = w_ge[k] ? (w_sh[k] - {1'b0, r_den[k]}) : w_sh[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nq[0]  <= w_an + (i_rnd ? DV_MAG_W'(w_ad >> 1) : '0);
            r_rem[0] <= '0;
            r_den[0] <= w_ad;
            r_neg[0] <= i_num[DV_NUM_W-1] ^ i_den[DV_DEN_W-1];
            for (int k = 0; k < DV_MAG_W; k++) begin
                r_rem[k+1] <= w_df[k][DV_DMAG_W-1:0];
                r_nq[k+1]  <= {r_nq[k][DV_MAG_W-2:0], w_ge[k]};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
            end
            r_quo <= r_neg[DV_MAG_W] ? -$signed({1'b0, r_nq[DV_MAG_W]})
                                     : $signed({1'b0, r_nq[DV_MAG_W]});
        end
    end

    assign o_quo = r_quo;

endmodule

[src/line_pair_corner_detect.sv]
// ----------------------------------------------------------------------------
// line_pair_corner_detect
// Corner test for one pair of line segments.
//
// Items enter on the i_in_valid / o_in_ready channel, one pair of segments
// with their gradients each, and leave on o_out_valid / i_out_ready with one
// result each. Registers are written on the i_cfg_valid / o_cfg_ready port,
// which always accepts; indexes past the register list are dropped.
// Throughput is one item per cycle while no result is held at the output.
// Stages: five front stages of subtracts and multiplies, a 25-stage square
// root for the segment lengths, a 54-stage divider bank for t, p,
// tolerances, unit directions and the corner point, three closing test stages.
// The whole pipeline advances together; while a result waits at the output
// and the receiver holds i_out_ready low, every stage freezes and o_in_ready
// is low, so nothing is lost or repeated.
// Reset clears all stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module line_pair_corner_detect (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [lpcd_pkg::COORD_W-1:0]    i_a_start_x,
    input  logic signed [lpcd_pkg::COORD_W-1:0]    i_a_start_y,
    input  logic signed [lpcd_pkg::COORD_W-1:0]    i_a_end_x,
    input  logic signed [lpcd_pkg::COORD_W-1:0]    i_a_end_y,
    input  logic signed [lpcd_pkg::COORD_W-1:0]    i_b_start_x,
    input  logic signed [lpcd_pkg::COORD_W-1:0]    i_b_start_y,
    input  logic signed [lpcd_pkg::COORD_W-1:0]    i_b_end_x,
    input  logic signed [lpcd_pkg::COORD_W-1:0]    i_b_end_y,
    input  logic signed [lpcd_pkg::G_W-1:0]        i_a_grad_x,
    input  logic signed [lpcd_pkg::G_W-1:0]        i_a_grad_y,
    input  logic signed [lpcd_pkg::G_W-1:0]        i_b_grad_x,
    input  logic signed [lpcd_pkg::G_W-1:0]        i_b_grad_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_valid_res,
    output logic signed [lpcd_pkg::COORD_W-1:0]    o_corner_x,
    output logic signed [lpcd_pkg::COORD_W-1:0]    o_corner_y,
    output logic signed [lpcd_pkg::OUT_DIR_W-1:0]  o_left_dir_x,
    output logic signed [lpcd_pkg::OUT_DIR_W-1:0]  o_left_dir_y,
    output logic signed [lpcd_pkg::OUT_DIR_W-1:0]  o_right_dir_x,
    output logic signed [lpcd_pkg::OUT_DIR_W-1:0]  o_right_dir_y,
    output logic signed [lpcd_pkg::G_W-1:0]        o_left_grad_x,
    output logic signed [lpcd_pkg::G_W-1:0]        o_left_grad_y,
    output logic signed [lpcd_pkg::G_W-1:0]        o_right_grad_x,
    output logic signed [lpcd_pkg::G_W-1:0]        o_right_grad_y,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lpcd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lpcd_pkg::REG_W-1:0]             i_cfg_data
);
    import lpcd_pkg::*;

    localparam int NDIV = 10;
    localparam int D_TQ = 0;
    localparam int D_PQ = 1;
    localparam int D_EA = 2;
    localparam int D_EB = 3;
    localparam int D_UAX = 4;
    localparam int D_UAY = 5;
    localparam int D_UBX = 6;
    localparam int D_UBY = 7;
    localparam int D_CX = 8;
    localparam int D_CY = 9;

    localparam logic signed [NR_W-1:0] T_ONE = NR_W'(1) <<< T_FRAC;
    localparam logic signed [DV_NUM_W-1:0] T_HALF = DV_NUM_W'(1) <<< (T_FRAC - 1);
    localparam logic signed [CS_W-1:0] C_MAX = CS_W'((64'sd1 <<< (COORD_W - 1)) - 1);
    localparam logic signed [CS_W-1:0] C_MIN = CS_W'(-(64'sd1 <<< (COORD_W - 1)));

    // configuration
    logic signed [REG_W-1:0] r_acute_lo, r_acute_hi, r_obtuse_lo, r_obtuse_hi;
    logic [REG_W-1:0]        r_tol;

    // control
    logic [NUM_STG-1:0] r_vld;
    logic               w_en;

    // front stages
    logic signed [COORD_W-1:0] r_ax0, r_ay0, r_ax1, r_ay1, r_bx0, r_by0, r_bx1, r_by1;
    logic signed [G_W-1:0]     r_gax, r_gay, r_gbx, r_gby;
    t_geo                      r_g2, r_g3, r_g4, r_g5;
    t_geo                      w_g2, w_g4, w_g5;
    logic signed [N_W-1:0]     r_dx2, r_dy2;
    logic signed [PROD_W-1:0]  r_paxx, r_payy, r_pbxx, r_pbyy, r_pc1, r_pc2;
    logic signed [PROD_W-1:0]  r_pt1, r_pt2, r_pp1, r_pp2;
    logic [L2_W-1:0]           r_la2_4, r_lb2_4, r_la2_5, r_lb2_5;

    // length and divider stages
    logic [SQ_W-1:0]           w_la, w_lb;
    t_geo                      r_gd [SQ_LAT];
    t_geo                      w_g30;
    t_tail                     r_td [DV_LAT];
    t_tail                     w_t84;
    logic signed [DV_NUM_W-1:0] w_dnum [NDIV];
    logic signed [DV_DEN_W-1:0] w_dden [NDIV];
    logic                       w_drnd [NDIV];
    logic signed [DV_NUM_W-1:0] w_dq   [NDIV];

    // closing stages
    logic signed [DV_NUM_W-1:0] w_ua_x, w_ua_y, w_ub_x, w_ub_y;
    logic                       w_sa_neg, w_sb_neg, w_a_left;
    logic                       r_f1_ok, r_f2_ok;
    logic signed [U_W-1:0]      r_f1_lx, r_f1_ly, r_f1_rx, r_f1_ry;
    logic signed [U_W-1:0]      r_f2_lx, r_f2_ly, r_f2_rx, r_f2_ry;
    logic signed [G_W-1:0]      r_f1_glx, r_f1_gly, r_f1_grx, r_f1_gry;
    logic signed [G_W-1:0]      r_f2_glx, r_f2_gly, r_f2_grx, r_f2_gry;
    logic signed [DV_NUM_W-1:0] r_f1_cx, r_f1_cy;
    logic signed [COORD_W-1:0]  r_f1_ax0, r_f1_ay0;
    logic signed [COORD_W-1:0]  r_f2_cx, r_f2_cy;
    logic signed [DOT_W-1:0]    r_f2_d1, r_f2_d2;
    logic signed [GP_W-1:0]     r_f2_gl1, r_f2_gl2, r_f2_gr1, r_f2_gr2;
    logic signed [CS_W-1:0]     w_sx, w_sy;
    logic signed [DOT_W-1:0]    w_dot;
    logic                       w_band, w_ok;

    function automatic logic f_near(input logic signed [DV_NUM_W-1:0] t,
                                    input logic signed [DV_NUM_W-1:0] e);
        logic signed [NR_W-1:0] tt;
        logic signed [NR_W-1:0] ee;
        tt = NR_W'(t);
        ee = NR_W'(e);
        return ((tt > -ee) && ((tt <<< 1) <= ee)) ||
               ((((T_ONE - tt) <<< 1) <= ee) && (tt < T_ONE + ee));
    endfunction

    function automatic logic f_in_band(input logic signed [DOT_W-1:0] d,
                                       input logic signed [REG_W-1:0] lo,
                                       input logic signed [REG_W-1:0] hi);
        return (d > (DOT_W'(lo) <<< DIR_FRAC)) && (d < (DOT_W'(hi) <<< DIR_FRAC));
    endfunction

    assign w_en        = !r_vld[NUM_STG-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[NUM_STG-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acute_lo  <= RST_ACUTE_LO;
            r_acute_hi  <= RST_ACUTE_HI;
            r_obtuse_lo <= RST_OBTUSE_LO;
            r_obtuse_hi <= RST_OBTUSE_HI;
            r_tol       <= RST_TOL;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ACUTE_LO:  r_acute_lo  <= $signed(i_cfg_data);
                CFG_ACUTE_HI:  r_acute_hi  <= $signed(i_cfg_data);
                CFG_OBTUSE_LO: r_obtuse_lo <= $signed(i_cfg_data);
                CFG_OBTUSE_HI: r_obtuse_hi <= $signed(i_cfg_data);
                CFG_TOL:       r_tol       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NUM_STG-2:0], i_in_valid};
        end
    end

    always_comb begin
        w_g2     = '0;
        w_g2.ax0 = r_ax0;
        w_g2.ay0 = r_ay0;
        w_g2.nax = N_W'(r_ax1) - N_W'(r_ax0);
        w_g2.nay = N_W'(r_ay1) - N_W'(r_ay0);
        w_g2.nbx = N_W'(r_bx1) - N_W'(r_bx0);
        w_g2.nby = N_W'(r_by1) - N_W'(r_by0);
        w_g2.gax = r_gax;
        w_g2.gay = r_gay;
        w_g2.gbx = r_gbx;
        w_g2.gby = r_gby;
    end

    always_comb begin
        w_g4    = r_g3;
        w_g4.cr = CR_W'(r_pc1) - CR_W'(r_pc2);
        w_g4.tn = CR_W'(r_pt1) - CR_W'(r_pt2);
        w_g4.pn = CR_W'(r_pp1) - CR_W'(r_pp2);
    end

    always_comb begin
        w_g5       = r_g4;
        w_g5.tnax  = TNA_W'(r_g4.tn) * TNA_W'(r_g4.nax);
        w_g5.tnay  = TNA_W'(r_g4.tn) * TNA_W'(r_g4.nay);
        w_g5.degen = (r_la2_4 == '0) || (r_lb2_4 == '0) || (r_g4.cr == '0);
    end

    // front: capture, differences, products, sums
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax0 <= i_a_start_x;
            r_ay0 <= i_a_start_y;
            r_ax1 <= i_a_end_x;
            r_ay1 <= i_a_end_y;
            r_bx0 <= i_b_start_x;
            r_by0 <= i_b_start_y;
            r_bx1 <= i_b_end_x;
            r_by1 <= i_b_end_y;
            r_gax <= i_a_grad_x;
            r_gay <= i_a_grad_y;
            r_gbx <= i_b_grad_x;
            r_gby <= i_b_grad_y;

            r_g2  <= w_g2;
            r_dx2 <= N_W'(r_bx0) - N_W'(r_ax0);
            r_dy2 <= N_W'(r_by0) - N_W'(r_ay0);

            r_g3   <= r_g2;
            r_paxx <= PROD_W'(r_g2.nax) * PROD_W'(r_g2.nax);
            r_payy <= PROD_W'(r_g2.nay) * PROD_W'(r_g2.nay);
            r_pbxx <= PROD_W'(r_g2.nbx) * PROD_W'(r_g2.nbx);
            r_pbyy <= PROD_W'(r_g2.nby) * PROD_W'(r_g2.nby);
            r_pc1  <= PROD_W'(r_g2.nax) * PROD_W'(r_g2.nby);
            r_pc2  <= PROD_W'(r_g2.nay) * PROD_W'(r_g2.nbx);
            r_pt1  <= PROD_W'(r_dx2) * PROD_W'(r_g2.nby);
            r_pt2  <= PROD_W'(r_dy2) * PROD_W'(r_g2.nbx);
            r_pp1  <= PROD_W'(r_dx2) * PROD_W'(r_g2.nay);
            r_pp2  <= PROD_W'(r_dy2) * PROD_W'(r_g2.nax);

            r_g4    <= w_g4;
            r_la2_4 <= L2_W'(r_paxx) + L2_W'(r_payy);
            r_lb2_4 <= L2_W'(r_pbxx) + L2_W'(r_pbyy);

            r_g5    <= w_g5;
            r_la2_5 <= r_la2_4;
            r_lb2_5 <= r_lb2_4;
        end
    end

    lpcd_sqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (SQ_IN_W'(r_la2_5) << T_FRAC),
        .o_root (w_la)
    );

    lpcd_sqrt u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (SQ_IN_W'(r_lb2_5) << T_FRAC),
        .o_root (w_lb)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gd[0] <= r_g5;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_gd[k] <= r_gd[k-1];
            end
            r_td[0].ax0    <= w_g30.ax0;
            r_td[0].ay0    <= w_g30.ay0;
            r_td[0].gax    <= w_g30.gax;
            r_td[0].gay    <= w_g30.gay;
            r_td[0].gbx    <= w_g30.gbx;
            r_td[0].gby    <= w_g30.gby;
            r_td[0].cr_neg <= w_g30.cr[CR_W-1];
            r_td[0].degen  <= w_g30.degen;
            for (int k = 1; k < DV_LAT; k++) begin
                r_td[k] <= r_td[k-1];
            end
        end
    end

    assign w_g30 = r_gd[SQ_LAT-1];
    assign w_t84 = r_td[DV_LAT-1];

    always_comb begin
        for (int k = 0; k < NDIV; k++) begin
            w_dnum[k] = '0;
            w_dden[k] = DV_DEN_W'(1);
            w_drnd[k] = 1'b1;
        end
        w_dnum[D_TQ]  = DV_NUM_W'(w_g30.tn) <<< T_FRAC;
        w_dden[D_TQ]  = DV_DEN_W'(w_g30.cr);
        w_dnum[D_PQ]  = DV_NUM_W'(w_g30.pn) <<< T_FRAC;
        w_dden[D_PQ]  = DV_DEN_W'(w_g30.cr);
        w_dnum[D_EA]  = DV_NUM_W'(r_tol) << EA_SH;
        w_dden[D_EA]  = DV_DEN_W'(w_la);
        w_drnd[D_EA]  = 1'b0;
        w_dnum[D_EB]  = DV_NUM_W'(r_tol) << EA_SH;
        w_dden[D_EB]  = DV_DEN_W'(w_lb);
        w_drnd[D_EB]  = 1'b0;
        w_dnum[D_UAX] = DV_NUM_W'(w_g30.nax) <<< (DIR_FRAC + 8);
        w_dden[D_UAX] = DV_DEN_W'(w_la);
        w_dnum[D_UAY] = DV_NUM_W'(w_g30.nay) <<< (DIR_FRAC + 8);
        w_dden[D_UAY] = DV_DEN_W'(w_la);
        w_dnum[D_UBX] = DV_NUM_W'(w_g30.nbx) <<< (DIR_FRAC + 8);
        w_dden[D_UBX] = DV_DEN_W'(w_lb);
        w_dnum[D_UBY] = DV_NUM_W'(w_g30.nby) <<< (DIR_FRAC + 8);
        w_dden[D_UBY] = DV_DEN_W'(w_lb);
        w_dnum[D_CX]  = DV_NUM_W'(w_g30.tnax);
        w_dden[D_CX]  = DV_DEN_W'(w_g30.cr);
        w_dnum[D_CY]  = DV_NUM_W'(w_g30.tnay);
        w_dden[D_CY]  = DV_DEN_W'(w_g30.cr);
    end

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        lpcd_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rnd (w_drnd[g]),
            .i_num (w_dnum[g]),
            .i_den (w_dden[g]),
            .o_quo (w_dq[g])
        );
    end

    // near tests, arm signs and left/right ordering
    always_comb begin
        w_sa_neg = (w_dq[D_TQ] > T_HALF);
        w_sb_neg = (w_dq[D_PQ] > T_HALF);
        w_ua_x   = w_sa_neg ? -w_dq[D_UAX] : w_dq[D_UAX];
        w_ua_y   = w_sa_neg ? -w_dq[D_UAY] : w_dq[D_UAY];
        w_ub_x   = w_sb_neg ? -w_dq[D_UBX] : w_dq[D_UBX];
        w_ub_y   = w_sb_neg ? -w_dq[D_UBY] : w_dq[D_UBY];
        w_a_left = w_t84.cr_neg ^ w_sa_neg ^ w_sb_neg;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_ok <= !w_t84.degen &&
                       f_near(w_dq[D_TQ], w_dq[D_EA]) && f_near(w_dq[D_PQ], w_dq[D_EB]);
            if (w_a_left) begin
                r_f1_lx  <= w_ua_x[U_W-1:0];
                r_f1_ly  <= w_ua_y[U_W-1:0];
                r_f1_rx  <= w_ub_x[U_W-1:0];
                r_f1_ry  <= w_ub_y[U_W-1:0];
                r_f1_glx <= w_t84.gax;
                r_f1_gly <= w_t84.gay;
                r_f1_grx <= w_t84.gbx;
                r_f1_gry <= w_t84.gby;
            end else begin
                r_f1_lx  <= w_ub_x[U_W-1:0];
                r_f1_ly  <= w_ub_y[U_W-1:0];
                r_f1_rx  <= w_ua_x[U_W-1:0];
                r_f1_ry  <= w_ua_y[U_W-1:0];
                r_f1_glx <= w_t84.gbx;
                r_f1_gly <= w_t84.gby;
                r_f1_grx <= w_t84.gax;
                r_f1_gry <= w_t84.gay;
            end
            r_f1_cx  <= w_dq[D_CX];
            r_f1_cy  <= w_dq[D_CY];
            r_f1_ax0 <= w_t84.ax0;
            r_f1_ay0 <= w_t84.ay0;
        end
    end

    // dot and side products, corner saturation
    always_comb begin
        w_sx = CS_W'(r_f1_ax0) + CS_W'(r_f1_cx);
        w_sy = CS_W'(r_f1_ay0) + CS_W'(r_f1_cy);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f2_ok  <= r_f1_ok;
            r_f2_d1  <= DOT_W'(r_f1_lx) * DOT_W'(r_f1_rx);
            r_f2_d2  <= DOT_W'(r_f1_ly) * DOT_W'(r_f1_ry);
            r_f2_gl1 <= GP_W'(r_f1_glx) * GP_W'(r_f1_ly);
            r_f2_gl2 <= GP_W'(r_f1_gly) * GP_W'(r_f1_lx);
            r_f2_gr1 <= GP_W'(r_f1_grx) * GP_W'(r_f1_ry);
            r_f2_gr2 <= GP_W'(r_f1_gry) * GP_W'(r_f1_rx);
            r_f2_cx  <= (w_sx > C_MAX) ? C_MAX[COORD_W-1:0] :
                        (w_sx < C_MIN) ? C_MIN[COORD_W-1:0] : w_sx[COORD_W-1:0];
            r_f2_cy  <= (w_sy > C_MAX) ? C_MAX[COORD_W-1:0] :
                        (w_sy < C_MIN) ? C_MIN[COORD_W-1:0] : w_sy[COORD_W-1:0];
            r_f2_lx  <= r_f1_lx;
            r_f2_ly  <= r_f1_ly;
            r_f2_rx  <= r_f1_rx;
            r_f2_ry  <= r_f1_ry;
            r_f2_glx <= r_f1_glx;
            r_f2_gly <= r_f1_gly;
            r_f2_grx <= r_f1_grx;
            r_f2_gry <= r_f1_gry;
        end
    end

    // band and side checks, output register
    always_comb begin
        w_dot  = r_f2_d1 + r_f2_d2;
        w_band = f_in_band(w_dot, r_acute_lo, r_acute_hi) ||
                 f_in_band(w_dot, r_obtuse_lo, r_obtuse_hi);
        w_ok   = r_f2_ok && w_band && ((r_f2_gl1 - r_f2_gl2) > 0) &&
                 ((r_f2_gr1 - r_f2_gr2) < 0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_valid_res <= w_ok;
            if (w_ok) begin
                o_corner_x     <= r_f2_cx;
                o_corner_y     <= r_f2_cy;
                o_left_dir_x   <= r_f2_lx[OUT_DIR_W-1:0];
                o_left_dir_y   <= r_f2_ly[OUT_DIR_W-1:0];
                o_right_dir_x  <= r_f2_rx[OUT_DIR_W-1:0];
                o_right_dir_y  <= r_f2_ry[OUT_DIR_W-1:0];
                o_left_grad_x  <= r_f2_glx;
                o_left_grad_y  <= r_f2_gly;
                o_right_grad_x <= r_f2_grx;
                o_right_grad_y <= r_f2_gry;
            end else begin
                o_corner_x     <= '0;
                o_corner_y     <= '0;
                o_left_dir_x   <= '0;
                o_left_dir_y   <= '0;
                o_right_dir_x  <= '0;
                o_right_dir_y  <= '0;
                o_left_grad_x  <= '0;
                o_left_grad_y  <= '0;
                o_right_grad_x <= '0;
                o_right_grad_y <= '0;
            end
        end
    end

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted item not in first stage");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res && $past(w_en) && $past(i_rst_n)) |->
            (o_corner_x == '0 && o_left_dir_x == '0 && o_right_grad_y == '0))
        else $error("rejected pair carries nonzero fields");

endmodule
